// ===== rtl/duty_limit_gain_compressor_core_macros.svh =====
// Assertion helpers shared by the compressor RTL.
// Every macro samples on clk and is disabled while arst_n is low.
`ifndef DUTY_LIMIT_GAIN_COMPRESSOR_CORE_MACROS_SVH
`define DUTY_LIMIT_GAIN_COMPRESSOR_CORE_MACROS_SVH

// Check a condition at every clock edge.
`define DLGC_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Check a consequent in the same cycle as its antecedent.
`define DLGC_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define DLGC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/dlgc_pkg.sv =====
package dlgc_pkg;

	localparam int unsigned GAIN_W = 11;

	localparam logic [GAIN_W-1:0] UNITY_GAIN  = 11'd1024;
	localparam logic [3:0]        CALL_DIVIDE = 4'd10;
	localparam logic [31:0]       DUTY_SCALE  = 32'd10000;

	// Reciprocals for exact unsigned 32-bit division by constants
	// x/10  = (x * RECIP_TEN) >> 35
	// x/255 = (x * RECIP_255) >> 39
	localparam logic [31:0] RECIP_TEN = 32'hCCCC_CCCD;
	localparam logic [31:0] RECIP_255 = 32'h8080_8081;

	typedef enum logic [1:0] {
		PH_ATTACK  = 2'd0,
		PH_SUSTAIN = 2'd1,
		PH_RELEASE = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		REG_ATTACK   = 2'd0,
		REG_SUSTAIN  = 2'd1,
		REG_RELEASE  = 2'd2,
		REG_MAX_DUTY = 2'd3
	} reg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_PROD,
		S_DIV10,
		S_ACC,
		S_VOL,
		S_DIV255,
		S_GAIN,
		S_LIMIT,
		S_DECIDE,
		S_OUT
	} state_t;

	typedef struct packed {
		logic [7:0] attack_step;
		logic [7:0] sustain_ticks;
		logic [7:0] release_step;
		logic [7:0] max_duty;
	} cfg_t;

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
	} mul_op_t;

	typedef struct packed {
		logic [15:0] on_time;
		logic [15:0] frequency;
		logic [1:0]  voice_copies;
		logic [7:0]  noise_level;
		logic [7:0]  master_volume;
		logic        last_voice;
	} item_t;

endpackage

// ===== rtl/dlgc_if.sv =====
// Voice item channel
interface dlgc_voice_if;
	logic        valid;
	logic        ready;
	logic [15:0] on_time;
	logic [15:0] frequency;
	logic [1:0]  voice_copies;
	logic [7:0]  noise_level;
	logic [7:0]  master_volume;
	logic        last_voice;

	modport source (
		output valid, on_time, frequency, voice_copies, noise_level, master_volume,
		last_voice,
		input  ready
	);
	modport sink (
		input  valid, on_time, frequency, voice_copies, noise_level, master_volume,
		last_voice,
		output ready
	);
endinterface

// Gain result channel
interface dlgc_result_if;
	logic        valid;
	logic        ready;
	logic [10:0] gain;
	logic [1:0]  phase;
	logic        evaluated;

	modport source (output valid, gain, phase, evaluated, input ready);
	modport sink   (input valid, gain, phase, evaluated, output ready);
endinterface

// ===== rtl/dlgc_apb_regs.sv =====
module dlgc_apb_regs (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [3:0]     paddr,
	input  logic [31:0]    pwdata,
	output logic [31:0]    prdata,
	output logic           pready,
	output dlgc_pkg::cfg_t cfg
);

	dlgc_pkg::cfg_t cfg_q;
	dlgc_pkg::reg_idx_t idx;
	logic wr_en;

	assign idx    = dlgc_pkg::reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// Write on the access beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (idx)
				dlgc_pkg::REG_ATTACK:   cfg_q.attack_step   <= pwdata[7:0];
				dlgc_pkg::REG_SUSTAIN:  cfg_q.sustain_ticks <= pwdata[7:0];
				dlgc_pkg::REG_RELEASE:  cfg_q.release_step  <= pwdata[7:0];
				dlgc_pkg::REG_MAX_DUTY: cfg_q.max_duty      <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		case (idx)
			dlgc_pkg::REG_ATTACK:   prdata = {24'd0, cfg_q.attack_step};
			dlgc_pkg::REG_SUSTAIN:  prdata = {24'd0, cfg_q.sustain_ticks};
			dlgc_pkg::REG_RELEASE:  prdata = {24'd0, cfg_q.release_step};
			dlgc_pkg::REG_MAX_DUTY: prdata = {24'd0, cfg_q.max_duty};
			default:                prdata = '0;
		endcase
	end

endmodule

// ===== rtl/dlgc_mul.sv =====
module dlgc_mul (
	input  logic              clk,
	input  dlgc_pkg::mul_op_t op,
	output logic [63:0]       product
);

	logic [63:0] product_s1;

	// One 32x32 multiply per cycle, result registered
	always_ff @(posedge clk) begin
		product_s1 <= {32'd0, op.a} * {32'd0, op.b};
	end

	assign product = product_s1;

endmodule

// ===== rtl/duty_limit_gain_compressor_core.sv =====
// Duty-limiting gain compressor. Voice items come in one at a time on the voice
// channel; a call is the run of items up to one with last_voice set, and only that
// closing item produces a beat on the result channel. Every tenth call is an
// evaluation that scales the summed duty by volume and gain, compares it with
// 10000*max_duty and steps the gain by the attack/sustain/release rule. All math
// runs through one shared 32x32 multiplier with a registered product, stepped by a
// small sequencer, and voice.ready is low while an item is in work. A non-closing
// item runs product, divide-by-ten and accumulate; a closing item adds output and
// waits while a result beat is pending; with nonzero attack_step an evaluating
// call adds volume, divide-by-255, gain, limit, decide. Configuration registers sit
// at byte addresses 0, 4, 8, 12 and must be written only while the block is idle.
`include "duty_limit_gain_compressor_core_macros.svh"

module duty_limit_gain_compressor_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [3:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready,
	dlgc_voice_if.sink    voice,
	dlgc_result_if.source result
);

	dlgc_pkg::cfg_t    cfg;
	dlgc_pkg::mul_op_t mul_op;
	logic [63:0]       product;

	dlgc_pkg::state_t  state_q, state_n;
	dlgc_pkg::item_t   item_q;
	dlgc_pkg::phase_t  phase_q, phase_n, res_phase_q;

	logic [31:0] work_q;
	logic [31:0] sum_q;
	logic [3:0]  div_q;
	logic [10:0] gain_q, gain_n, res_gain_q;
	logic [7:0]  hold_q, hold_n, hold_base;
	logic        eval_q, res_eval_q, res_valid_q;

	logic        accept;
	logic        slot_free;
	logic        load_result;
	logic [28:0] duty;
	logic [31:0] sum_new;
	logic [3:0]  div_next;
	logic        eval_hit;
	logic        comp_off;
	logic [11:0] gain_up;

	dlgc_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	dlgc_mul u_mul (
		.clk     (clk),
		.op      (mul_op),
		.product (product)
	);

	assign accept    = voice.valid && voice.ready;
	assign slot_free = !res_valid_q || result.ready;

	// Accumulate step: quotient of the divide-by-ten multiply, doubled for a clean pair
	assign duty     = product[63:35];
	assign sum_new  = sum_q + ((item_q.voice_copies == 2'd2 && item_q.noise_level == 8'd0)
		? {2'd0, duty, 1'b0} : {3'd0, duty});
	assign div_next = div_q + 4'd1;
	assign eval_hit = (div_next == dlgc_pkg::CALL_DIVIDE);
	assign comp_off = (cfg.attack_step == 8'd0);

	// Next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			dlgc_pkg::S_IDLE:   if (accept) state_n = dlgc_pkg::S_PROD;
			dlgc_pkg::S_PROD:   state_n = dlgc_pkg::S_DIV10;
			dlgc_pkg::S_DIV10:  state_n = dlgc_pkg::S_ACC;
			dlgc_pkg::S_ACC: begin
				if (!item_q.last_voice)
					state_n = dlgc_pkg::S_IDLE;
				else if (eval_hit && !comp_off)
					state_n = dlgc_pkg::S_VOL;
				else
					state_n = dlgc_pkg::S_OUT;
			end
			dlgc_pkg::S_VOL:    state_n = dlgc_pkg::S_DIV255;
			dlgc_pkg::S_DIV255: state_n = dlgc_pkg::S_GAIN;
			dlgc_pkg::S_GAIN:   state_n = dlgc_pkg::S_LIMIT;
			dlgc_pkg::S_LIMIT:  state_n = dlgc_pkg::S_DECIDE;
			dlgc_pkg::S_DECIDE: state_n = dlgc_pkg::S_OUT;
			dlgc_pkg::S_OUT:    if (slot_free) state_n = dlgc_pkg::S_IDLE;
			default:            state_n = dlgc_pkg::S_IDLE;
		endcase
	end

	// Sequencer outputs: handshake and multiplier operands
	always_comb begin
		voice.ready = 1'b0;
		load_result = 1'b0;
		mul_op      = '0;
		case (state_q)
			dlgc_pkg::S_IDLE:   voice.ready = 1'b1;
			dlgc_pkg::S_PROD:   mul_op = '{a: {16'd0, item_q.on_time}, b: {16'd0, item_q.frequency}};
			dlgc_pkg::S_DIV10:  mul_op = '{a: product[31:0], b: dlgc_pkg::RECIP_TEN};
			dlgc_pkg::S_VOL:    mul_op = '{a: work_q, b: {24'd0, item_q.master_volume}};
			dlgc_pkg::S_DIV255: mul_op = '{a: product[31:0], b: dlgc_pkg::RECIP_255};
			dlgc_pkg::S_GAIN:   mul_op = '{a: {7'd0, product[63:39]}, b: {21'd0, gain_q}};
			dlgc_pkg::S_LIMIT:  mul_op = '{a: dlgc_pkg::DUTY_SCALE, b: {24'd0, cfg.max_duty}};
			dlgc_pkg::S_OUT:    load_result = slot_free;
			default: ;
		endcase
	end

	// Gain rule: work_q holds the scaled duty, product the limit
	always_comb begin
		gain_n    = gain_q;
		phase_n   = phase_q;
		hold_n    = hold_q;
		hold_base = (phase_q == dlgc_pkg::PH_ATTACK) ? 8'd0 : hold_q;
		gain_up   = {1'b0, gain_q} + {4'd0, cfg.release_step};
		if (work_q > product[31:0]) begin
			phase_n = dlgc_pkg::PH_ATTACK;
			gain_n  = (gain_q < {3'd0, cfg.attack_step}) ? 11'd0
				: gain_q - {3'd0, cfg.attack_step};
		end else if (work_q < product[31:0]) begin
			case (phase_q)
				dlgc_pkg::PH_ATTACK, dlgc_pkg::PH_SUSTAIN: begin
					if (hold_base == cfg.sustain_ticks) begin
						phase_n = dlgc_pkg::PH_RELEASE;
						hold_n  = 8'd0;
					end else begin
						phase_n = dlgc_pkg::PH_SUSTAIN;
						hold_n  = hold_base + 8'd1;
					end
				end
				dlgc_pkg::PH_RELEASE: begin
					if (gain_q != dlgc_pkg::UNITY_GAIN)
						gain_n = (gain_up >= {1'b0, dlgc_pkg::UNITY_GAIN})
							? dlgc_pkg::UNITY_GAIN : gain_up[10:0];
				end
				default: ;
			endcase
		end
	end

	// Control and compressor state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dlgc_pkg::S_IDLE;
			sum_q       <= '0;
			div_q       <= '0;
			gain_q      <= dlgc_pkg::UNITY_GAIN;
			phase_q     <= dlgc_pkg::PH_ATTACK;
			hold_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (state_q == dlgc_pkg::S_ACC) begin
				if (item_q.last_voice) begin
					sum_q <= '0;
					div_q <= eval_hit ? 4'd0 : div_next;
					if (eval_hit && comp_off)
						gain_q <= dlgc_pkg::UNITY_GAIN;
				end else begin
					sum_q <= sum_new;
				end
			end
			if (state_q == dlgc_pkg::S_DECIDE) begin
				gain_q  <= gain_n;
				phase_q <= phase_n;
				hold_q  <= hold_n;
			end
			// Drop the beat once taken, refill when a result is ready
			if (load_result)
				res_valid_q <= 1'b1;
			else if (result.ready)
				res_valid_q <= 1'b0;
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= '{on_time: voice.on_time, frequency: voice.frequency,
				voice_copies: voice.voice_copies, noise_level: voice.noise_level,
				master_volume: voice.master_volume, last_voice: voice.last_voice};
		end
		if (state_q == dlgc_pkg::S_ACC) begin
			work_q <= sum_new;
			eval_q <= item_q.last_voice && eval_hit;
		end
		// Keep the scaled duty: low 32 bits of the gain product, shifted down by ten
		if (state_q == dlgc_pkg::S_LIMIT)
			work_q <= {10'd0, product[31:10]};
		if (load_result) begin
			res_gain_q  <= gain_q;
			res_phase_q <= phase_q;
			res_eval_q  <= eval_q;
		end
	end

	assign result.valid     = res_valid_q;
	assign result.gain      = res_gain_q;
	assign result.phase     = res_phase_q;
	assign result.evaluated = res_eval_q;

	`DLGC_ASSERT_ALWAYS(a_gain_bound, gain_q <= dlgc_pkg::UNITY_GAIN, "gain above unity")
	`DLGC_ASSERT_SAME(a_result_on_close, $rose(res_valid_q), item_q.last_voice,
		"result beat without closing voice")
	`DLGC_ASSERT_NEXT(a_sum_cleared, state_q == dlgc_pkg::S_ACC && item_q.last_voice,
		sum_q == 32'd0, "duty sum not cleared after closing voice")

endmodule
